@@ sv/scan_disk_scheduler_core_defines.svh @@
// Assertion macros shared by the scan scheduler modules.
`ifndef SCAN_DISK_SCHEDULER_CORE_DEFINES_SVH
`define SCAN_DISK_SCHEDULER_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sds_pkg.sv @@
// Types and constants of the scan disk scheduler.
package sds_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t DEPTH_CNT = cnt_t'(QUEUE_DEPTH);

	localparam logic [16:0] MOVE_CAP = 17'h1FFFF;

	localparam logic [15:0] HEAD_START_RST = 16'd143;
	localparam logic [15:0] MAX_CYL_RST = 16'd4999;

	// request types
	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_RUN = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// visit kinds
	localparam logic [1:0] KIND_HEAD = 2'd0;
	localparam logic [1:0] KIND_SERVED = 2'd1;
	localparam logic [1:0] KIND_TURN = 2'd2;

	// filter applied to a stored request against the head
	localparam logic [1:0] COND_GE = 2'd0;
	localparam logic [1:0] COND_LT = 2'd1;
	localparam logic [1:0] COND_LE = 2'd2;
	localparam logic [1:0] COND_GT = 2'd3;

	// configuration register indexes
	localparam logic CFG_HEAD_START = 1'b0;
	localparam logic CFG_MAX_CYL = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] cylinder;
		logic direction;
	} item_t;

	typedef struct packed {
		logic [15:0] position;
		logic [1:0] visit_kind;
		logic [16:0] total_movement;
		logic last;
	} result_t;

	// visit candidate handed from the sequencer to the visit unit
	typedef struct packed {
		logic valid;
		logic flush;
		logic from_mem;
		logic [1:0] kind;
		logic [1:0] cond;
		logic [15:0] pos;
	} cand_t;

endpackage

@@ sv/sds_ram.sv @@
// Generic single-port-write, registered-read RAM.
module sds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/sds_ctrl.sv @@
// Sequencer: sorted insertion into the request RAM and scan read ordering.
`include "scan_disk_scheduler_core_defines.svh"

module sds_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input sds_pkg::item_t item,
	input logic [15:0] head_start,
	input logic [15:0] max_cylinder,
	output logic busy,
	output logic ram_we,
	output sds_pkg::addr_t ram_waddr,
	output logic [15:0] ram_wdata,
	output sds_pkg::addr_t ram_raddr,
	input logic [15:0] ram_rdata,
	output sds_pkg::cand_t cand
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS = 2'd1;
	localparam logic [1:0] ST_P1 = 2'd2;
	localparam logic [1:0] ST_P2 = 2'd3;

	logic [1:0] state_q;
	sds_pkg::cnt_t count_q;
	sds_pkg::cnt_t rem_q;
	sds_pkg::addr_t idx_q;
	sds_pkg::addr_t ins_q;
	logic [15:0] cyl_q;
	logic dir_q;
	sds_pkg::cand_t cand_s1;

	logic accept;
	logic ins_done;
	sds_pkg::addr_t last_addr;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign last_addr = sds_pkg::addr_t'(count_q - sds_pkg::cnt_t'(1));
	// slot reached bottom, or the entry below is not larger: place the new cylinder
	assign ins_done = (ins_q == '0) || (ram_rdata <= cyl_q);
	assign cand = cand_s1;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = ins_q;
		ram_wdata = cyl_q;
		ram_raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = last_addr;
			end
			ST_INS: begin
				ram_we = 1'b1;
				ram_wdata = ins_done ? cyl_q : ram_rdata;
				ram_raddr = ins_q - sds_pkg::addr_t'(2);
			end
			ST_P1, ST_P2: begin
				ram_raddr = idx_q;
			end
			default: begin
				ram_raddr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cand_s1 <= '0;
		end else begin
			cand_s1.valid <= 1'b0;
			cand_s1.flush <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.req_type)
							sds_pkg::REQ_ADD: begin
								if (count_q < sds_pkg::DEPTH_CNT) begin
									cyl_q <= item.cylinder;
									ins_q <= sds_pkg::addr_t'(count_q);
									state_q <= ST_INS;
								end
							end
							sds_pkg::REQ_RUN: begin
								dir_q <= item.direction;
								rem_q <= count_q;
								idx_q <= item.direction ? '0 : last_addr;
								cand_s1.valid <= 1'b1;
								cand_s1.from_mem <= 1'b0;
								cand_s1.kind <= sds_pkg::KIND_HEAD;
								cand_s1.pos <= head_start;
								state_q <= ST_P1;
							end
							sds_pkg::REQ_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_INS: begin
					if (ins_done) begin
						count_q <= count_q + sds_pkg::cnt_t'(1);
						state_q <= ST_IDLE;
					end else begin
						ins_q <= ins_q - sds_pkg::addr_t'(1);
					end
				end
				ST_P1: begin
					cand_s1.valid <= 1'b1;
					if (rem_q == '0) begin
						cand_s1.from_mem <= 1'b0;
						cand_s1.kind <= sds_pkg::KIND_TURN;
						cand_s1.pos <= dir_q ? max_cylinder : 16'd0;
						rem_q <= count_q;
						idx_q <= dir_q ? last_addr : '0;
						state_q <= ST_P2;
					end else begin
						cand_s1.from_mem <= 1'b1;
						cand_s1.kind <= sds_pkg::KIND_SERVED;
						cand_s1.cond <= dir_q ? sds_pkg::COND_GE : sds_pkg::COND_LE;
						idx_q <= dir_q ? idx_q + sds_pkg::addr_t'(1) : idx_q - sds_pkg::addr_t'(1);
						rem_q <= rem_q - sds_pkg::cnt_t'(1);
					end
				end
				ST_P2: begin
					if (rem_q == '0) begin
						// last read is in flight; close the run after it
						cand_s1.flush <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cand_s1.valid <= 1'b1;
						cand_s1.from_mem <= 1'b1;
						cand_s1.kind <= sds_pkg::KIND_SERVED;
						cand_s1.cond <= dir_q ? sds_pkg::COND_LT : sds_pkg::COND_GT;
						idx_q <= dir_q ? idx_q - sds_pkg::addr_t'(1) : idx_q + sds_pkg::addr_t'(1);
						rem_q <= rem_q - sds_pkg::cnt_t'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SDS_ASSERT(a_count_range, count_q <= sds_pkg::DEPTH_CNT, "request count past depth")
	`SDS_ASSERT(a_ins_room, (state_q != ST_INS) || (count_q < sds_pkg::DEPTH_CNT), "insert into full store")
	`SDS_ASSERT_NEXT(a_run_starts, accept && (item.req_type == sds_pkg::REQ_RUN), (state_q == ST_P1) && cand_s1.valid, "run did not start")
	`SDS_ASSERT(a_flush_alone, !(cand_s1.valid && cand_s1.flush), "flush collides with a visit")

endmodule

@@ sv/sds_visit.sv @@
// Visit unit: filters candidates, accumulates movement, drives result beats.
`include "scan_disk_scheduler_core_defines.svh"

module sds_visit (
	input logic clk,
	input logic arst_n,
	input sds_pkg::cand_t cand,
	input logic [15:0] ram_rdata,
	input logic [15:0] head_start,
	output logic result_valid,
	output sds_pkg::result_t result
);

	logic pend_valid_q;
	logic [15:0] pend_pos_q;
	logic [1:0] pend_kind_q;
	logic [16:0] pend_total_q;
	logic res_valid_q;
	sds_pkg::result_t res_q;

	logic [15:0] pos;
	logic keep;
	logic [15:0] seek_len;
	logic [17:0] sum;
	logic [16:0] new_total;

	always_comb begin
		pos = cand.from_mem ? ram_rdata : cand.pos;
		keep = 1'b1;
		if (cand.from_mem) begin
			unique case (cand.cond)
				sds_pkg::COND_GE: keep = (ram_rdata >= head_start);
				sds_pkg::COND_LT: keep = (ram_rdata < head_start);
				sds_pkg::COND_LE: keep = (ram_rdata <= head_start);
				sds_pkg::COND_GT: keep = (ram_rdata > head_start);
				default: keep = 1'b0;
			endcase
		end
		seek_len = (pos >= pend_pos_q) ? (pos - pend_pos_q) : (pend_pos_q - pos);
		sum = {1'b0, pend_total_q} + {2'b00, seek_len};
		if (cand.kind == sds_pkg::KIND_HEAD) begin
			new_total = '0;
		end else if (sum > {1'b0, sds_pkg::MOVE_CAP}) begin
			new_total = sds_pkg::MOVE_CAP;
		end else begin
			new_total = sum[16:0];
		end
	end

	// one visit is held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cand.flush) begin
				res_valid_q <= pend_valid_q;
				res_q.position <= pend_pos_q;
				res_q.visit_kind <= pend_kind_q;
				res_q.total_movement <= pend_total_q;
				res_q.last <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (cand.valid && keep) begin
				res_valid_q <= pend_valid_q;
				res_q.position <= pend_pos_q;
				res_q.visit_kind <= pend_kind_q;
				res_q.total_movement <= pend_total_q;
				res_q.last <= 1'b0;
				pend_valid_q <= 1'b1;
				pend_pos_q <= pos;
				pend_kind_q <= cand.kind;
				pend_total_q <= new_total;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	`SDS_ASSERT(a_flush_pending, !cand.flush || pend_valid_q, "run closed with no visit held")
	`SDS_ASSERT(a_head_first, !(cand.valid && (cand.kind == sds_pkg::KIND_HEAD)) || !pend_valid_q, "head visit while a run is open")
	`SDS_ASSERT_NEXT(a_beat_source, !pend_valid_q, !res_valid_q, "beat without a held visit")

endmodule

@@ sv/scan_disk_scheduler_core.sv @@
// Top level: SCAN disk scheduler with sorted request RAM.
// Add: busy while larger entries are shifted up to place the new cylinder; an add to a full
// store is dropped. Clear: not busy. Run: busy through both scan passes; the first beat is
// the head visit, then at most one beat per cycle; the last beat comes after busy drops.
// Results cannot be stalled. Reset: request count 0, config regs 143 and 4999;
// RAM contents are undefined and never used beyond the count.
module scan_disk_scheduler_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	input sds_pkg::item_t item,
	output logic busy,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data,
	output logic result_valid,
	output sds_pkg::result_t result
);

	logic [15:0] head_start_q;
	logic [15:0] max_cyl_q;

	logic ram_we;
	sds_pkg::addr_t ram_waddr;
	sds_pkg::addr_t ram_raddr;
	logic [15:0] ram_wdata;
	logic [15:0] ram_rdata;
	sds_pkg::cand_t cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_start_q <= sds_pkg::HEAD_START_RST;
			max_cyl_q <= sds_pkg::MAX_CYL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sds_pkg::CFG_HEAD_START: head_start_q <= cfg_data;
				sds_pkg::CFG_MAX_CYL: max_cyl_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sds_ram #(
		.WIDTH(16),
		.DEPTH(sds_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sds_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.head_start(head_start_q),
		.max_cylinder(max_cyl_q),
		.busy(busy),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.cand(cand)
	);

	sds_visit u_visit (
		.clk(clk),
		.arst_n(arst_n),
		.cand(cand),
		.ram_rdata(ram_rdata),
		.head_start(head_start_q),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

@@ test/scan_disk_scheduler_core_tb.sv @@
// Self-checking testbench for the SCAN disk scheduler core.
`timescale 1ns / 1ps

module scan_disk_scheduler_core_tb;

	localparam int SETTLE_CYCLES = sds_pkg::QUEUE_DEPTH + 8;
	localparam int RANDOM_ITEMS = 255;
	localparam int RANDOM_PHASES = 6;
	localparam int CYCLE_LIMIT = 300000;
	// request type code with no function
	localparam logic [1:0] REQ_RSVD = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	sds_pkg::item_t item;
	logic busy;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;
	logic result_valid;
	sds_pkg::result_t result;

	// predictor state
	logic [15:0] queued_cyls[$];
	logic [15:0] head_cfg;
	logic [15:0] max_cfg;
	sds_pkg::result_t due_visits[$];
	sds_pkg::result_t want_visit;

	logic steady;
	int fails;
	int items_sent;
	int scans_sent;
	int visits_seen;
	int cycles;

	scan_disk_scheduler_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Expected visit list of one scan, from the current store and config.
	function automatic void plan_scan(input logic up);
		logic [15:0] stops[$];
		logic [1:0] kinds[$];
		int unsigned here;
		int unsigned moved;
		int unsigned step;
		sds_pkg::result_t r;
		stops.push_back(head_cfg);
		kinds.push_back(sds_pkg::KIND_HEAD);
		if (up) begin
			for (int i = 0; i < queued_cyls.size(); i++)
				if (queued_cyls[i] >= head_cfg) begin
					stops.push_back(queued_cyls[i]);
					kinds.push_back(sds_pkg::KIND_SERVED);
				end
			stops.push_back(max_cfg);
			kinds.push_back(sds_pkg::KIND_TURN);
			for (int i = queued_cyls.size() - 1; i >= 0; i--)
				if (queued_cyls[i] < head_cfg) begin
					stops.push_back(queued_cyls[i]);
					kinds.push_back(sds_pkg::KIND_SERVED);
				end
		end else begin
			for (int i = queued_cyls.size() - 1; i >= 0; i--)
				if (queued_cyls[i] <= head_cfg) begin
					stops.push_back(queued_cyls[i]);
					kinds.push_back(sds_pkg::KIND_SERVED);
				end
			stops.push_back(16'd0);
			kinds.push_back(sds_pkg::KIND_TURN);
			for (int i = 0; i < queued_cyls.size(); i++)
				if (queued_cyls[i] > head_cfg) begin
					stops.push_back(queued_cyls[i]);
					kinds.push_back(sds_pkg::KIND_SERVED);
				end
		end
		here = 32'(head_cfg);
		moved = 0;
		for (int k = 0; k < stops.size(); k++) begin
			step = (32'(stops[k]) >= here) ? 32'(stops[k]) - here : here - 32'(stops[k]);
			moved = moved + step;
			if (moved > 32'(sds_pkg::MOVE_CAP))
				moved = 32'(sds_pkg::MOVE_CAP);
			here = 32'(stops[k]);
			r.position = stops[k];
			r.visit_kind = kinds[k];
			r.total_movement = moved[16:0];
			r.last = (k == stops.size() - 1);
			due_visits.push_back(r);
		end
	endfunction

	function automatic void accept_item(input sds_pkg::item_t it);
		int slot;
		items_sent++;
		case (it.req_type)
			sds_pkg::REQ_ADD: begin
				// full store drops the request
				if (queued_cyls.size() < sds_pkg::QUEUE_DEPTH) begin
					slot = queued_cyls.size();
					while (slot > 0 && queued_cyls[slot-1] > it.cylinder)
						slot--;
					queued_cyls.insert(slot, it.cylinder);
				end
			end
			sds_pkg::REQ_RUN: begin
				scans_sent++;
				plan_scan(it.direction);
			end
			sds_pkg::REQ_CLEAR: queued_cyls.delete();
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			visits_seen++;
			if (due_visits.size() == 0) begin
				$error("unexpected visit beat: position %0d kind %0d", result.position,
					result.visit_kind);
				fails++;
			end else begin
				want_visit = due_visits.pop_front();
				if (result.position !== want_visit.position) begin
					$error("position: expected %0d, got %0d", want_visit.position,
						result.position);
					fails++;
				end
				if (result.visit_kind !== want_visit.visit_kind) begin
					$error("visit_kind: expected %0d, got %0d", want_visit.visit_kind,
						result.visit_kind);
					fails++;
				end
				if (result.total_movement !== want_visit.total_movement) begin
					$error("total_movement: expected %0d, got %0d",
						want_visit.total_movement, result.total_movement);
					fails++;
				end
				if (result.last !== want_visit.last) begin
					$error("last: expected %0d, got %0d", want_visit.last, result.last);
					fails++;
				end
			end
		end
	end

	task automatic send_item(input sds_pkg::item_t it);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		accept_item(it);
		if (!steady && $urandom_range(0, 99) < 30) begin
			start <= 1'b0;
			item <= sds_pkg::item_t'($urandom);
			repeat ($urandom_range(1, 3) == 1 ? $urandom_range(7, 40) : $urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic send(input logic [1:0] kind, input logic [15:0] cyl, input logic dir);
		sds_pkg::item_t it;
		it.req_type = kind;
		it.cylinder = cyl;
		it.direction = dir;
		send_item(it);
	endtask

	// adds give no beat, so wait out a worst-case insertion after the last one
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (due_visits.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sds_pkg::CFG_HEAD_START)
			head_cfg = val;
		else
			max_cfg = val;
		@(posedge clk);
	endtask

	task automatic test_empty_store();
		send(sds_pkg::REQ_RUN, 16'd0, 1'b1);
		send(sds_pkg::REQ_RUN, 16'hFFFF, 1'b0);
		settle();
	endtask

	task automatic test_basic_requests();
		send(sds_pkg::REQ_ADD, 16'd0, 1'b0);
		send(sds_pkg::REQ_ADD, 16'hFFFF, 1'b1);
		send(sds_pkg::REQ_ADD, head_cfg, 1'b0);
		send(sds_pkg::REQ_ADD, 16'd500, 1'b1);
		send(sds_pkg::REQ_ADD, 16'd500, 1'b0);
		send(REQ_RSVD, 16'd77, 1'b1);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b1);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b0);
		send(sds_pkg::REQ_CLEAR, 16'd0, 1'b0);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b1);
		settle();
	endtask

	// head above the end cylinder and a movement total that saturates
	task automatic test_turn_and_saturation();
		write_reg(sds_pkg::CFG_HEAD_START, 16'hFFFF);
		write_reg(sds_pkg::CFG_MAX_CYL, 16'd1);
		send(sds_pkg::REQ_ADD, 16'hFFFF, 1'b0);
		send(sds_pkg::REQ_ADD, 16'hFFFE, 1'b0);
		send(sds_pkg::REQ_ADD, 16'd0, 1'b0);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b1);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b0);
		settle();
		write_reg(sds_pkg::CFG_HEAD_START, 16'd0);
		write_reg(sds_pkg::CFG_MAX_CYL, 16'hFFFF);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b0);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b1);
		send(sds_pkg::REQ_CLEAR, 16'd0, 1'b1);
		settle();
	endtask

	// falling cylinders make every insertion shift the whole store; the last adds are dropped
	task automatic test_full_store();
		send(sds_pkg::REQ_CLEAR, 16'd0, 1'b0);
		for (int n = 0; n < sds_pkg::QUEUE_DEPTH + 2; n++)
			send(sds_pkg::REQ_ADD, 16'(4000 - 100 * n), 1'(n));
		send(sds_pkg::REQ_RUN, 16'd0, 1'b1);
		send(sds_pkg::REQ_RUN, 16'd0, 1'b0);
		send(sds_pkg::REQ_CLEAR, 16'd0, 1'b0);
		settle();
	endtask

	function automatic logic [15:0] pick_cylinder();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom);
			4, 5: return 16'(head_cfg + $urandom_range(0, 40) - 20);
			6: return head_cfg;
			7: return 16'($urandom_range(0, 15));
			8: return max_cfg;
			default: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
		endcase
	endfunction

	task automatic test_random_traffic();
		int sent;
		int per_phase;
		int roll;
		logic [1:0] kind;
		sent = 0;
		per_phase = RANDOM_ITEMS / RANDOM_PHASES + 1;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0: write_reg(sds_pkg::CFG_HEAD_START, 16'd0);
				1: write_reg(sds_pkg::CFG_HEAD_START, 16'hFFFF);
				2: write_reg(sds_pkg::CFG_HEAD_START, 16'($urandom_range(0, 400)));
				default: write_reg(sds_pkg::CFG_HEAD_START, 16'($urandom));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(sds_pkg::CFG_MAX_CYL, 16'd1);
				1: write_reg(sds_pkg::CFG_MAX_CYL, 16'hFFFF);
				default: write_reg(sds_pkg::CFG_MAX_CYL, 16'($urandom_range(1, 65535)));
			endcase
			steady = (phase == 2);
			for (int n = 0; n < per_phase && sent < RANDOM_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 62)
					kind = sds_pkg::REQ_ADD;
				else if (roll < 87)
					kind = sds_pkg::REQ_RUN;
				else if (roll < 95)
					kind = sds_pkg::REQ_CLEAR;
				else
					kind = REQ_RSVD;
				send(kind, pick_cylinder(), 1'($urandom));
				sent++;
			end
			steady = 1'b0;
			settle();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= sds_pkg::CFG_HEAD_START;
		cfg_data <= '0;
		cycles = 0;
		fails = 0;
		items_sent = 0;
		scans_sent = 0;
		visits_seen = 0;
		steady = 1'b0;
		head_cfg = sds_pkg::HEAD_START_RST;
		max_cfg = sds_pkg::MAX_CYL_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_basic_requests();
		test_turn_and_saturation();
		test_full_store();
		test_random_traffic();

		$display("covered %0d items, %0d scans, %0d visit beats checked",
			items_sent, scans_sent, visits_seen);
		$display("incl. full store, head at end, saturation and unused request type");
		if (fails == 0 && due_visits.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sds_pkg.sv
sv/sds_ram.sv
sv/sds_ctrl.sv
sv/sds_visit.sv
sv/scan_disk_scheduler_core.sv
test/scan_disk_scheduler_core_tb.sv
